/* design/stt_pkg.sv */
// Shared types and constants for the periodic software timer table.
// Used by stt_ctrl, stt_dp and software_timer_table_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  localparam int TIMER_SLOTS = 8;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int RESULT_CAP  = 8;
  localparam int CNT_W       = $clog2(RESULT_CAP + 1);

  typedef enum logic [2:0] {
    FUNC_TICK   = 3'd0,
    FUNC_CREATE = 3'd1,
    FUNC_START  = 3'd2,
    FUNC_STOP   = 3'd3,
    FUNC_DELETE = 3'd4
  } func_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  timer_id;
    logic [31:0] period;
    logic        notify_enable;
    logic [31:0] timebase;
  } in_word_t;

  typedef struct packed {
    logic       status;
    logic       fired;
    logic [7:0] fired_id;
    logic [2:0] fired_slot;
    logic       last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic              load;
    logic              step;
    logic              finish;
    logic [SLOT_W-1:0] idx;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_block;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* design/stt_ctrl.sv */
// Sequencer for the timer table: accept a word, walk every slot, finish.
// Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire stt_pkg::dp_sts_t   sts_i,
  output stt_pkg::ctrl_cmd_t      cmd_o
);

  localparam logic [stt_pkg::SLOT_W-1:0] LastIdx =
    stt_pkg::SLOT_W'(stt_pkg::TIMER_SLOTS - 1);

  stt_pkg::state_e             state_q, state_d;
  logic [stt_pkg::SLOT_W-1:0]  idx_q, idx_d;

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cmd_o.load    = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.finish  = 1'b0;
    cmd_o.idx     = idx_q;
    unique case (state_q)
      stt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = stt_pkg::ST_SCAN;
        end
      end
      stt_pkg::ST_SCAN: begin
        if (!sts_i.scan_block) begin
          cmd_o.step = 1'b1;
          if (idx_q == LastIdx) begin
            state_d = stt_pkg::ST_DONE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      stt_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = stt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = stt_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != stt_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stt_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

/* design/stt_dp.sv */
// Timer table datapath: slot storage, per-slot update, pending expiry
// and output register. Depends on stt_pkg; driven by stt_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module stt_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire stt_pkg::in_word_t   in_word_i,
  input  wire stt_pkg::ctrl_cmd_t  cmd_i,
  output stt_pkg::dp_sts_t         sts_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output stt_pkg::out_word_t       out_word_o
);

  localparam int N = stt_pkg::TIMER_SLOTS;

  stt_pkg::in_word_t in_q;

  logic        valid_q [N];
  logic        run_q   [N];
  logic        ntf_q   [N];
  logic [7:0]  id_q    [N];
  logic [31:0] per_q   [N];
  logic [31:0] ela_q   [N];

  // create bookkeeping
  logic                        dup_q;
  logic                        found_q;
  logic [stt_pkg::SLOT_W-1:0]  free_q;

  // expiry held back until we know whether it is the last one
  logic                        pend_v_q;
  stt_pkg::out_word_t          pend_q;
  logic [stt_pkg::CNT_W-1:0]   n_q;

  logic                        out_valid_q;
  stt_pkg::out_word_t          out_q;

  logic [stt_pkg::SLOT_W-1:0]  sel;
  logic                        is_tick, is_create, is_start, is_stop, is_delete;
  logic [32:0]                 sum;
  logic                        active, hit, report, match, create_ok, out_free;
  stt_pkg::out_word_t          new_pend, final_word;

  assign sel       = cmd_i.idx;
  assign is_tick   = (in_q.func == stt_pkg::FUNC_TICK);
  assign is_create = (in_q.func == stt_pkg::FUNC_CREATE);
  assign is_start  = (in_q.func == stt_pkg::FUNC_START);
  assign is_stop   = (in_q.func == stt_pkg::FUNC_STOP);
  assign is_delete = (in_q.func == stt_pkg::FUNC_DELETE);

  assign active  = valid_q[sel] && run_q[sel];
  assign sum     = {1'b0, ela_q[sel]} + {1'b0, in_q.timebase};
  assign hit     = active && (sum >= {1'b0, per_q[sel]});
  assign report  = is_tick && hit && ntf_q[sel] &&
                   (n_q < stt_pkg::CNT_W'(stt_pkg::RESULT_CAP));
  assign match   = valid_q[sel] && (id_q[sel] == in_q.timer_id);
  assign create_ok = is_create && !dup_q && found_q;

  assign out_free = !out_valid_q || !out_stall_i;
  // a second expiry needs the output register to push out the pending one
  assign sts_o.scan_block = report && pend_v_q && !out_free;
  assign sts_o.out_free   = out_free;

  always_comb begin
    new_pend            = '0;
    new_pend.fired      = 1'b1;
    new_pend.fired_id   = id_q[sel];
    // slot index reported modulo 8
    new_pend.fired_slot = 3'(sel);

    final_word      = '0;
    final_word.last = 1'b1;
    if (is_tick && pend_v_q) begin
      final_word      = pend_q;
      final_word.last = 1'b1;
    end else if (is_create) begin
      final_word.status = !(found_q && !dup_q);
    end
  end

  // command word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_word_i;
    end
  end

  // slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        valid_q[i] <= 1'b0;
        run_q[i]   <= 1'b0;
        ntf_q[i]   <= 1'b0;
      end
    end else begin
      if (cmd_i.step && match) begin
        if (is_start) begin
          run_q[sel] <= 1'b1;
        end else if (is_stop) begin
          run_q[sel] <= 1'b0;
        end else if (is_delete) begin
          valid_q[sel] <= 1'b0;
        end
      end
      if (cmd_i.finish && create_ok) begin
        valid_q[free_q] <= 1'b1;
        run_q[free_q]   <= 1'b1;
        ntf_q[free_q]   <= in_q.notify_enable;
      end
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && is_tick && active) begin
      ela_q[sel] <= hit ? 32'd0 : sum[31:0];
    end
    if (cmd_i.finish && create_ok) begin
      id_q[free_q]  <= in_q.timer_id;
      per_q[free_q] <= in_q.period;
      ela_q[free_q] <= 32'd0;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dup_q    <= 1'b0;
      found_q  <= 1'b0;
      free_q   <= '0;
      pend_v_q <= 1'b0;
      n_q      <= '0;
    end else if (cmd_i.load) begin
      dup_q    <= 1'b0;
      found_q  <= 1'b0;
      pend_v_q <= 1'b0;
      n_q      <= '0;
    end else if (cmd_i.step) begin
      if (match) begin
        dup_q <= 1'b1;
      end
      if (!valid_q[sel] && !found_q) begin
        found_q <= 1'b1;
        free_q  <= sel;
      end
      if (report) begin
        pend_v_q <= 1'b1;
        n_q      <= n_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && report) begin
      pend_q <= new_pend;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.step && report && pend_v_q) || cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && report && pend_v_q) begin
      out_q <= pend_q;
    end else if (cmd_i.finish) begin
      out_q <= final_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= stt_pkg::CNT_W'(stt_pkg::RESULT_CAP))
    else $error("expiry count above cap");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> !pend_v_q && (n_q == '0))
    else $error("pending expiry survived a new word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && report && pend_v_q) |=> out_valid_q && !out_q.last)
    else $error("pushed expiry lost or flagged last");

endmodule

`default_nettype wire

/* design/software_timer_table_top.sv */
// Periodic software timer table, top level: stt_ctrl sequencer plus
// stt_dp datapath. Depends on stt_pkg, stt_ctrl and stt_dp.
//
// One word is taken at a time. After acceptance the sequencer visits each
// of the TIMER_SLOTS slots in turn, then writes the final result, and
// only then returns to idle to take the next word. A tick reports each
// notifying expiry, up to RESULT_CAP, as its own result word in slot order,
// the final one marked last; the scan waits on the output register whenever
// a stalled result is still in front of a new expiry. Commands and empty
// ticks return one word.
`timescale 1ns / 1ps
`default_nettype none

module software_timer_table_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire stt_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output stt_pkg::out_word_t      out_word_o
);

  stt_pkg::ctrl_cmd_t cmd;
  stt_pkg::dp_sts_t   sts;

  stt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.step && sts.scan_block))
    else $error("scan advanced while output blocked");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> sts.out_free)
    else $error("final word written over an unsent result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second word taken before scan");

endmodule

`default_nettype wire

/* dv/tb_software_timer_table_top.sv */
// Testbench for software_timer_table_top: directed table plus random commands,
// each result word checked against a given result or a timer-table predictor.
// Depends on stt_pkg and the software_timer_table_top RTL.
`timescale 1ns / 1ps

module tb_software_timer_table_top;
  import stt_pkg::*;

  localparam int          RAND_WORDS  = 420;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          MAX_WAIT    = 13;
  localparam int          TAIL_CYCLES = 2 * TIMER_SLOTS + 4;
  localparam logic [2:0]  FUNC_BAD_LO = 3'd5;  // funcs 5..7 are ignored
  localparam logic [2:0]  FUNC_BAD_HI = 3'd7;
  localparam out_word_t   RES_OK  = '{status: 1'b0, fired: 1'b0, fired_id: 8'h00,
                                      fired_slot: 3'd0, last: 1'b1};
  localparam out_word_t   RES_ERR = '{status: 1'b1, fired: 1'b0, fired_id: 8'h00,
                                      fired_slot: 3'd0, last: 1'b1};

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } step_row_t;

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_stall;
  in_word_t  in_word     = '0;
  logic      out_valid;
  logic      out_stall   = 1'b0;
  out_word_t out_word;

  // timer table as the bench sees it
  logic        tm_valid   [TIMER_SLOTS];
  logic        tm_running [TIMER_SLOTS];
  logic [7:0]  tm_id      [TIMER_SLOTS];
  logic [31:0] tm_period  [TIMER_SLOTS];
  logic [31:0] tm_elapsed [TIMER_SLOTS];
  logic        tm_notify  [TIMER_SLOTS];

  out_word_t   fire_buf [RESULT_CAP];
  int          fire_cnt;
  out_word_t   pending_words [$];
  step_row_t   dir_tab [$];
  int          errors  = 0;
  int          cycles  = 0;
  int          rx_wait = 0;
  bit          calm    = 1'b0;

  software_timer_table_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               pending_words.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] %s", $time, msg);
  endfunction

  // Expected result words of one accepted word; updates the table.
  function automatic void predict_word(input in_word_t w);
    logic [32:0] total;
    logic        dup;
    int          free_slot;
    out_word_t   res;
    fire_cnt  = 0;
    dup       = 1'b0;
    free_slot = -1;
    res       = RES_OK;
    case (w.func)
      FUNC_TICK: begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (!(tm_valid[i] && tm_running[i])) continue;
          total = {1'b0, tm_elapsed[i]} + {1'b0, w.timebase};
          if (total >= {1'b0, tm_period[i]}) begin
            tm_elapsed[i] = '0;
            if (tm_notify[i] && fire_cnt < RESULT_CAP) begin
              fire_buf[fire_cnt] = '{status: 1'b0, fired: 1'b1, fired_id: tm_id[i],
                                     fired_slot: 3'(i), last: 1'b0};
              fire_cnt++;
            end
          end else begin
            tm_elapsed[i] = total[31:0];
          end
        end
        if (fire_cnt > 0) fire_buf[fire_cnt-1].last = 1'b1;
      end
      FUNC_CREATE: begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (tm_valid[i]) begin
            if (tm_id[i] == w.timer_id) dup = 1'b1;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (dup || free_slot < 0) begin
          res = RES_ERR;
        end else begin
          tm_valid[free_slot]   = 1'b1;
          tm_running[free_slot] = 1'b1;
          tm_id[free_slot]      = w.timer_id;
          tm_period[free_slot]  = w.period;
          tm_elapsed[free_slot] = '0;
          tm_notify[free_slot]  = w.notify_enable;
        end
      end
      FUNC_START, FUNC_STOP, FUNC_DELETE: begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (!tm_valid[i] || tm_id[i] != w.timer_id) continue;
          if (w.func == FUNC_START)     tm_running[i] = 1'b1;
          else if (w.func == FUNC_STOP) tm_running[i] = 1'b0;
          else                          tm_valid[i]   = 1'b0;
        end
      end
      default: ;
    endcase
    if (fire_cnt == 0) begin
      fire_buf[0] = res;
      fire_cnt    = 1;
    end
  endfunction

  // Result side: random stall per word, compare against the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      rx_wait = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          note_error($sformatf("unexpected word st=%0d fi=%0d id=%02h slot=%0d last=%0d",
                               out_word.status, out_word.fired, out_word.fired_id,
                               out_word.fired_slot, out_word.last));
        end else begin
          want = pending_words.pop_front();
          if (out_word.status !== want.status || out_word.fired !== want.fired ||
              out_word.fired_id !== want.fired_id ||
              out_word.fired_slot !== want.fired_slot || out_word.last !== want.last)
            note_error($sformatf({"mismatch exp st=%0d fi=%0d id=%02h slot=%0d last=%0d",
                                  " got st=%0d fi=%0d id=%02h slot=%0d last=%0d"},
                                 want.status, want.fired, want.fired_id,
                                 want.fired_slot, want.last,
                                 out_word.status, out_word.fired, out_word.fired_id,
                                 out_word.fired_slot, out_word.last));
        end
        rx_wait = calm ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait != 0);
    end
  end

  // Present one word after a random gap, hold until taken, then predict.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t res);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_word(w);
    if (typed) begin
      pending_words.push_back(res);
    end else begin
      for (int k = 0; k < fire_cnt; k++) pending_words.push_back(fire_buf[k]);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  task automatic add_row(input logic [2:0] func, input logic [7:0] id,
                         input logic [31:0] per, input logic ntf,
                         input logic [31:0] tb, input bit typed, input out_word_t res);
    step_row_t r;
    r.w     = '{func: func, timer_id: id, period: per, notify_enable: ntf, timebase: tb};
    r.typed = typed;
    r.res   = res;
    dir_tab.push_back(r);
  endtask

  // Mostly small ids, periods and timebases so timers collide and expire often.
  function automatic in_word_t rand_word();
    in_word_t    w;
    int          r;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    w   = raw[$bits(in_word_t)-1:0];
    r = $urandom_range(0, 99);
    if (r < 40)      w.func = FUNC_TICK;
    else if (r < 62) w.func = FUNC_CREATE;
    else if (r < 72) w.func = FUNC_START;
    else if (r < 82) w.func = FUNC_STOP;
    else if (r < 95) w.func = FUNC_DELETE;
    else             w.func = 3'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI));
    if ($urandom_range(0, 9) < 8) w.timer_id = 8'($urandom_range(0, 9));
    r = $urandom_range(0, 99);
    if (r < 8)       w.period = '0;
    else if (r < 12) w.period = '1;
    else if (r >= 25) w.period = $urandom_range(1, 40);
    r = $urandom_range(0, 99);
    if (r < 10)      w.timebase = '0;
    else if (r < 15) w.timebase = '1;
    else if (r >= 22) w.timebase = $urandom_range(1, 12);
    w.notify_enable = ($urandom_range(0, 3) != 0);
    return w;
  endfunction

  initial begin
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      tm_valid[i]   = 1'b0;
      tm_running[i] = 1'b0;
      tm_id[i]      = '0;
      tm_period[i]  = '0;
      tm_elapsed[i] = '0;
      tm_notify[i]  = 1'b0;
    end

    add_row(FUNC_TICK,   8'h00, 32'h0,       1'b0, 32'h0,         1, RES_OK);
    add_row(FUNC_BAD_HI, 8'hff, 32'hffffffff, 1'b1, 32'hffffffff, 1, RES_OK);
    add_row(FUNC_BAD_LO, 8'h55, 32'h0,       1'b0, 32'h0,         1, RES_OK);
    add_row(FUNC_CREATE, 8'h55, 32'h0,       1'b1, 32'hffffffff,  1, RES_OK);
    add_row(FUNC_CREATE, 8'h55, 32'h7,       1'b0, 32'h0,         1, RES_ERR);
    // zero period fires on a zero timebase
    add_row(FUNC_TICK,   8'h00, 32'h0,       1'b0, 32'h0,         0, RES_OK);
    add_row(FUNC_CREATE, 8'hff, 32'hffffffff, 1'b1, 32'h0,        1, RES_OK);
    add_row(FUNC_TICK,   8'h00, 32'h0,       1'b0, 32'hfffffffe,  0, RES_OK);
    // count + timebase exceeds 32 bits: must expire, not wrap
    add_row(FUNC_TICK,   8'h00, 32'h0,       1'b0, 32'hffffffff,  0, RES_OK);
    add_row(FUNC_STOP,   8'h55, 32'h0,       1'b0, 32'h0,         1, RES_OK);
    add_row(FUNC_TICK,   8'h00, 32'h0,       1'b0, 32'h3,         0, RES_OK);
    add_row(FUNC_START,  8'h55, 32'h0,       1'b0, 32'h0,         1, RES_OK);
    add_row(FUNC_CREATE, 8'h00, 32'h5,       1'b0, 32'h0,         1, RES_OK);
    // silent expiry on the notify-off timer
    add_row(FUNC_TICK,   8'h00, 32'h0,       1'b0, 32'h5,         0, RES_OK);
    add_row(FUNC_DELETE, 8'hff, 32'h0,       1'b0, 32'h0,         1, RES_OK);
    add_row(FUNC_STOP,   8'h12, 32'h0,       1'b0, 32'h0,         1, RES_OK);
    for (int k = 1; k <= 6; k++)
      add_row(FUNC_CREATE, 8'(k), 32'h2,     1'b1, 32'h0,         1, RES_OK);
    add_row(FUNC_CREATE, 8'h07, 32'h2,       1'b1, 32'h0,         1, RES_ERR);
    add_row(FUNC_TICK,   8'h00, 32'h0,       1'b0, 32'hffffffff,  0, RES_OK);
    add_row(FUNC_DELETE, 8'h00, 32'h0,       1'b0, 32'h0,         1, RES_OK);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[j]) send_word(dir_tab[j].w, dir_tab[j].typed, dir_tab[j].res);
    drain_results();

    for (int n = 0; n < RAND_WORDS; n++) begin
      calm = (n >= 140 && n < 220);
      if (n == 300) drain_results();
      send_word(rand_word(), 0, RES_OK);
    end
    calm = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
